// ===== rtl/core/perspective_texture_span_addresser_unit_defines.svh =====
// Assertion shorthands used by the checker file.
// Each one clocks on clk and stays quiet while arst_n is low.
`ifndef PERSPECTIVE_TEXTURE_SPAN_ADDRESSER_UNIT_DEFINES_SVH
`define PERSPECTIVE_TEXTURE_SPAN_ADDRESSER_UNIT_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define PTSA_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define PTSA_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/ptsa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ptsa_pkg;

	// Field widths
	localparam int VAL_W     = 32;
	localparam int FRAC_W    = 16;
	localparam int SPAN_W    = 13;
	localparam int SKIP_W    = 12;
	localparam int IDX_W     = 16;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;

	// Defaults for the top-level parameters
	localparam int MAX_SPAN_DEF   = 4096;
	localparam int INDEX_BITS_DEF = 16;

	// Opcodes
	localparam logic OP_SETUP = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_U_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_V_BITS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TEX_EN = 2'd2;

	// Configuration reset values
	localparam logic [CFG_W-1:0] U_BITS_RST = 5'd8;
	localparam logic [CFG_W-1:0] V_BITS_RST = 5'd8;
	localparam logic             TEX_EN_RST = 1'b1;
	localparam logic [CFG_W-1:0] TEX_BITS_MAX = 5'd16;

	// Lanes: u, v, w
	localparam int NLANE  = 3;
	localparam int NPIX   = 2;
	localparam int LANE_W = 2;

	// Saturation limits
	localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

	// Serial divider geometry
	localparam int DIV_NUM_W = VAL_W + 1;
	localparam int DIV_REM_W = VAL_W;
	localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);
	localparam logic [DIV_CNT_W-1:0] SETUP_DIV_STEPS = DIV_CNT_W'(DIV_NUM_W);
	localparam logic [DIV_CNT_W-1:0] PIX_DIV_STEPS   = DIV_CNT_W'(VAL_W - 1);

	// Serial multiply-accumulate geometry
	localparam int ACC_W     = VAL_W + SKIP_W + 1;
	localparam int MAC_CNT_W = $clog2(SKIP_W + 1);

	typedef struct packed {
		logic [DIV_REM_W-1:0] rem;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_CNT_W-1:0] steps;
		logic [VAL_W-1:0]     den;
	} div_load_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] base;
		logic signed [VAL_W-1:0] mcand;
		logic [SKIP_W-1:0]       mplier;
	} mac_load_t;

endpackage

`default_nettype wire

// ===== rtl/core/ptsa_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input item channel
interface ptsa_in_if;
	logic                                valid;
	logic                                ready;
	logic                                opcode;
	logic signed [ptsa_pkg::VAL_W-1:0]   start_u;
	logic signed [ptsa_pkg::VAL_W-1:0]   start_v;
	logic signed [ptsa_pkg::VAL_W-1:0]   start_w;
	logic signed [ptsa_pkg::VAL_W-1:0]   end_u;
	logic signed [ptsa_pkg::VAL_W-1:0]   end_v;
	logic signed [ptsa_pkg::VAL_W-1:0]   end_w;
	logic [ptsa_pkg::SPAN_W-1:0]         span_length;
	logic [ptsa_pkg::SKIP_W-1:0]         skip_count;
	logic [ptsa_pkg::SPAN_W-1:0]         pixel_count;

	modport source (
		output valid, opcode, start_u, start_v, start_w, end_u, end_v, end_w,
		output span_length, skip_count, pixel_count,
		input  ready
	);
	modport sink (
		input  valid, opcode, start_u, start_v, start_w, end_u, end_v, end_w,
		input  span_length, skip_count, pixel_count,
		output ready
	);
endinterface

// Result channel
interface ptsa_out_if;
	logic                          valid;
	logic                          ready;
	logic [ptsa_pkg::IDX_W-1:0]    texel_index;
	logic                          last_pixel;

	modport source (output valid, texel_index, last_pixel, input ready);
	modport sink (input valid, texel_index, last_pixel, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/perspective_texture_span_addresser_unit.sv =====
// Perspective-correct texel addresser for one horizontal span. A setup item
// (opcode 0) takes u, v, w at both span ends and computes per-pixel steps and
// the values at the first drawn pixel; it produces no result. After the
// load, three parallel radix-2 dividers each produce 33 quotient bits of
// (end - start) / span_length and hand over to three bit-serial
// multiply-accumulates over the 12 bits of skip_count. A pixel item
// (opcode 1) produces one texel index from u/w and v/w and then steps u,
// v, w: after the load, two parallel dividers produce 31 quotient bits
// each, the divide finishes and the index is formed. A pixel item arriving
// with texturing off or no pixels left is dropped with no result.
// Items are worked one at a time; a finished texel waits in an output
// register, so the next item is taken while it is still unclaimed. A pixel
// that finishes while the previous texel is still unclaimed holds in its last
// cycle until that texel is taken. There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module perspective_texture_span_addresser_unit #(
	parameter int MAX_SPAN   = ptsa_pkg::MAX_SPAN_DEF,
	parameter int INDEX_BITS = ptsa_pkg::INDEX_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [ptsa_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ptsa_pkg::CFG_W-1:0]         cfg_wdata,
	ptsa_in_if.sink                                 item,
	ptsa_out_if.source                              texel
);

	localparam int VW    = ptsa_pkg::VAL_W;
	localparam int FW    = ptsa_pkg::FRAC_W;
	localparam int NW    = ptsa_pkg::DIV_NUM_W;
	localparam int IW    = ptsa_pkg::IDX_W;
	localparam int NL    = ptsa_pkg::NLANE;
	localparam int NP    = ptsa_pkg::NPIX;
	localparam int LW    = ptsa_pkg::LANE_W;
	localparam int CNT_W = $clog2(MAX_SPAN + 1);
	localparam logic [IW-1:0] IDX_MASK = IW'((32'd1 << INDEX_BITS) - 32'd1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SDIV = 3'd1;
	localparam logic [2:0] ST_SMAC = 3'd2;
	localparam logic [2:0] ST_PDIV = 3'd3;
	localparam logic [2:0] ST_PFIN = 3'd4;

	localparam logic [IW-1:0] INT_POS_SAT = 16'h7FFF;
	localparam logic [IW-1:0] INT_NEG_SAT = 16'h8000;

	// Control and configuration
	logic [2:0]                 state_q;
	logic [ptsa_pkg::CFG_W-1:0] u_bits_q;
	logic [ptsa_pkg::CFG_W-1:0] v_bits_q;
	logic                       tex_en_q;

	// Span state
	logic signed [VW-1:0]          cur_q  [NL];
	logic signed [VW-1:0]          step_q [NL];
	logic [CNT_W-1:0]              pix_left_q;
	logic [ptsa_pkg::SKIP_W-1:0]   skip_q;
	logic [NL-1:0]                 neg_q;
	logic [NP-1:0]                 sat_q;
	logic                          last_q;

	// Output register
	logic                          out_valid_q;
	logic [IW-1:0]                 tex_idx_q;
	logic                          tex_last_q;

	// Lane datapath
	logic signed [VW-1:0]     s_val [NL];
	logic signed [VW-1:0]     e_val [NL];
	logic [VW-1:0]            abs_c [NL];
	logic [VW-1:0]            abs_w;
	logic [NW-1:0]            diff_c [NL];
	logic [NW-1:0]            abs_d [NL];
	logic [NL-1:0]            neg_set;
	logic [NP-1:0]            neg_pix;
	logic [NP-1:0]            sat_pix;
	logic signed [VW-1:0]     step_d [NL];
	logic [VW-1:0]            len_raw;
	logic [VW-1:0]            len_nz;
	logic [VW-1:0]            len_c;
	logic [VW-1:0]            cnt_raw;
	logic [VW-1:0]            cnt_c;

	ptsa_pkg::div_load_t      div_ld   [NL];
	ptsa_pkg::mac_load_t      mac_ld   [NL];
	logic [NL-1:0]            div_start;
	logic [NL-1:0]            div_done;
	logic [NW-1:0]            div_quot [NL];
	logic                     mac_start;
	logic [NL-1:0]            mac_done;
	logic signed [VW-1:0]     mac_res  [NL];

	// Index forming
	logic [VW-1:0]            mag   [NP];
	logic [VW-1:0]            qv    [NP];
	logic [IW-1:0]            int_d [NP];
	logic [ptsa_pkg::CFG_W-1:0] ub;
	logic [ptsa_pkg::CFG_W-1:0] vb;
	logic [VW-1:0]            umask;
	logic [VW-1:0]            vmask;
	logic [VW-1:0]            idx_wide;
	logic [IW-1:0]            idx_d;

	logic                     in_xfer;
	logic                     setup_go;
	logic                     pix_go;
	logic                     fin_fire;

	function automatic logic signed [VW-1:0] sat_add(
		input logic signed [VW-1:0] a,
		input logic signed [VW-1:0] b
	);
		logic [VW:0] s;
		s = {a[VW-1], a} + {b[VW-1], b};
		if (s[VW] != s[VW-1]) begin
			return s[VW] ? ptsa_pkg::SAT_MIN : ptsa_pkg::SAT_MAX;
		end
		return s[VW-1:0];
	endfunction

	assign s_val[0] = item.start_u;
	assign s_val[1] = item.start_v;
	assign s_val[2] = item.start_w;
	assign e_val[0] = item.end_u;
	assign e_val[1] = item.end_v;
	assign e_val[2] = item.end_w;

	// Handshake decode
	assign item.ready = (state_q == ST_IDLE);
	assign in_xfer    = item.valid && item.ready;
	assign setup_go   = in_xfer && (item.opcode == ptsa_pkg::OP_SETUP);
	assign pix_go     = in_xfer && (item.opcode == ptsa_pkg::OP_PIXEL) && tex_en_q
		&& (pix_left_q != '0);
	assign fin_fire   = (state_q == ST_PFIN) && (!out_valid_q || texel.ready);
	assign mac_start  = (state_q == ST_SDIV) && div_done[0];

	// Clamp span length and pixel count
	always_comb begin
		len_raw = VW'(item.span_length);
		len_nz  = (len_raw == '0) ? 32'd1 : len_raw;
		len_c   = (len_nz > VW'(MAX_SPAN)) ? VW'(MAX_SPAN) : len_nz;
		cnt_raw = VW'(item.pixel_count);
		cnt_c   = (cnt_raw > VW'(MAX_SPAN)) ? VW'(MAX_SPAN) : cnt_raw;
	end

	// Build divider and multiplier loads, and saturate the quotients into steps
	always_comb begin
		abs_w = cur_q[LW][VW-1] ? (~cur_q[LW] + 32'd1) : cur_q[LW];
		for (int l = 0; l < NL; l++) begin
			abs_c[l]   = cur_q[l][VW-1] ? (~cur_q[l] + 32'd1) : cur_q[l];
			diff_c[l]  = {e_val[l][VW-1], e_val[l]} - {s_val[l][VW-1], s_val[l]};
			neg_set[l] = diff_c[l][NW-1];
			abs_d[l]   = neg_set[l] ? (~diff_c[l] + 33'd1) : diff_c[l];
			if (item.opcode == ptsa_pkg::OP_SETUP) begin
				div_ld[l].rem   = '0;
				div_ld[l].num   = abs_d[l];
				div_ld[l].steps = ptsa_pkg::SETUP_DIV_STEPS;
				div_ld[l].den   = len_c;
			end else begin
				div_ld[l].rem   = VW'(abs_c[l][VW-1:FW-1]);
				div_ld[l].num   = {abs_c[l][FW-2:0], {(NW-FW+1){1'b0}}};
				div_ld[l].steps = ptsa_pkg::PIX_DIV_STEPS;
				div_ld[l].den   = abs_w;
			end
			if (neg_q[l]) begin
				step_d[l] = (div_quot[l] > {1'b0, ptsa_pkg::SAT_MIN}) ? ptsa_pkg::SAT_MIN
					: (~div_quot[l][VW-1:0] + 32'd1);
			end else begin
				step_d[l] = (div_quot[l] > {1'b0, ptsa_pkg::SAT_MAX}) ? ptsa_pkg::SAT_MAX
					: div_quot[l][VW-1:0];
			end
			mac_ld[l].base   = cur_q[l];
			mac_ld[l].mcand  = step_d[l];
			mac_ld[l].mplier = skip_q;
			div_start[l]     = setup_go || (pix_go && (l != LW));
		end
		for (int l = 0; l < NP; l++) begin
			neg_pix[l] = cur_q[l][VW-1] ^ cur_q[LW][VW-1];
			sat_pix[l] = VW'(abs_c[l][VW-1:FW-1]) >= abs_w;
		end
	end

	// Form the texel index from the integer parts of u/w and v/w
	always_comb begin
		for (int l = 0; l < NP; l++) begin
			mag[l] = div_quot[l][VW-1:0];
			qv[l]  = neg_q[l] ? (~mag[l] + 32'd1) : mag[l];
			if (sat_q[l]) begin
				int_d[l] = neg_q[l] ? INT_NEG_SAT : INT_POS_SAT;
			end else begin
				int_d[l] = qv[l][VW-1:FW];
			end
		end
		ub       = (u_bits_q > ptsa_pkg::TEX_BITS_MAX) ? ptsa_pkg::TEX_BITS_MAX : u_bits_q;
		vb       = (v_bits_q > ptsa_pkg::TEX_BITS_MAX) ? ptsa_pkg::TEX_BITS_MAX : v_bits_q;
		umask    = (32'd1 << ub) - 32'd1;
		vmask    = (32'd1 << vb) - 32'd1;
		idx_wide = ((VW'(int_d[1]) & vmask) << ub) | (VW'(int_d[0]) & umask);
		idx_d    = idx_wide[IW-1:0] & IDX_MASK;
	end

	// Lanes: u, v, w each own a divider and a multiply-accumulate unit
	for (genvar g = 0; g < NL; g++) begin : g_lane
		ptsa_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start[g]),
			.ld     (div_ld[g]),
			.done   (div_done[g]),
			.quot   (div_quot[g])
		);

		ptsa_mac u_mac (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (mac_start),
			.ld     (mac_ld[g]),
			.done   (mac_done[g]),
			.res    (mac_res[g])
		);
	end

	// Sequencer, configuration and span state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			u_bits_q   <= ptsa_pkg::U_BITS_RST;
			v_bits_q   <= ptsa_pkg::V_BITS_RST;
			tex_en_q   <= ptsa_pkg::TEX_EN_RST;
			pix_left_q <= '0;
			for (int l = 0; l < NL; l++) begin
				cur_q[l]  <= '0;
				step_q[l] <= '0;
			end
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					ptsa_pkg::CFG_U_BITS: u_bits_q <= cfg_wdata;
					ptsa_pkg::CFG_V_BITS: v_bits_q <= cfg_wdata;
					ptsa_pkg::CFG_TEX_EN: tex_en_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (setup_go) begin
						for (int l = 0; l < NL; l++) begin
							cur_q[l] <= s_val[l];
						end
						pix_left_q <= cnt_c[CNT_W-1:0];
						state_q    <= ST_SDIV;
					end else if (pix_go) begin
						for (int l = 0; l < NL; l++) begin
							cur_q[l] <= sat_add(cur_q[l], step_q[l]);
						end
						pix_left_q <= pix_left_q - CNT_W'(1);
						state_q    <= ST_PDIV;
					end
				end
				ST_SDIV: begin
					if (div_done[0]) begin
						for (int l = 0; l < NL; l++) begin
							step_q[l] <= step_d[l];
						end
						state_q <= ST_SMAC;
					end
				end
				ST_SMAC: begin
					if (mac_done[0]) begin
						for (int l = 0; l < NL; l++) begin
							cur_q[l] <= mac_res[l];
						end
						state_q <= ST_IDLE;
					end
				end
				ST_PDIV: begin
					if (div_done[0]) begin
						state_q <= ST_PFIN;
					end
				end
				ST_PFIN: begin
					if (fin_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Capture per-item flags at the input transfer
	always_ff @(posedge clk) begin
		if (setup_go) begin
			neg_q  <= neg_set;
			skip_q <= item.skip_count;
		end else if (pix_go) begin
			neg_q[NP-1:0] <= neg_pix;
			sat_q         <= sat_pix;
			last_q        <= (pix_left_q == CNT_W'(1));
		end
	end

	// Hold the result until the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_fire) begin
			out_valid_q <= 1'b1;
		end else if (texel.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_fire) begin
			tex_idx_q  <= idx_d;
			tex_last_q <= last_q;
		end
	end

	assign texel.valid       = out_valid_q;
	assign texel.texel_index = tex_idx_q;
	assign texel.last_pixel  = tex_last_q;

endmodule

`default_nettype wire

// ===== rtl/core/ptsa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Radix-2 restoring divider, one quotient bit per cycle. The caller loads
// the starting partial remainder and the dividend bits still to be shifted
// in (MSB first), and the number of quotient bits to produce.
module ptsa_div (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire ptsa_pkg::div_load_t               ld,
	output logic                                   done,
	output logic [ptsa_pkg::DIV_NUM_W-1:0]         quot
);

	localparam int NW = ptsa_pkg::DIV_NUM_W;
	localparam int RW = ptsa_pkg::DIV_REM_W;
	localparam int CW = ptsa_pkg::DIV_CNT_W;

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [NW-1:0] num_q;
	logic [RW-1:0] den_q;
	logic [NW-1:0] quot_q;

	logic [RW:0]   trial;
	logic [RW:0]   trial_sub;
	logic          ge;

	// Trial subtract of the divisor from the shifted remainder
	always_comb begin
		trial     = {rem_q, num_q[NW-1]};
		trial_sub = trial - {1'b0, den_q};
		ge        = trial >= {1'b0, den_q};
	end

	assign done = busy_q && (cnt_q == '0);
	assign quot = quot_q;

	// Count down the quotient bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ld.steps;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Shift one dividend bit in and one quotient bit out per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= ld.rem;
			num_q  <= ld.num;
			den_q  <= ld.den;
			quot_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			rem_q  <= ge ? trial_sub[RW-1:0] : trial[RW-1:0];
			num_q  <= {num_q[NW-2:0], 1'b0};
			quot_q <= {quot_q[NW-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ptsa_mac.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bit-serial multiply-accumulate: base + mcand * mplier, multiplier bits
// taken MSB first, then one saturating add to the signed 32-bit range.
module ptsa_mac (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	input  wire ptsa_pkg::mac_load_t                  ld,
	output logic                                      done,
	output logic signed [ptsa_pkg::VAL_W-1:0]         res
);

	localparam int VW = ptsa_pkg::VAL_W;
	localparam int AW = ptsa_pkg::ACC_W;
	localparam int SW = ptsa_pkg::SKIP_W;
	localparam int CW = ptsa_pkg::MAC_CNT_W;

	logic                 busy_q;
	logic [CW-1:0]        cnt_q;
	logic signed [AW-1:0] acc_q;
	logic [SW-1:0]        mpl_q;
	logic signed [VW-1:0] mcand_q;
	logic signed [VW-1:0] base_q;

	logic signed [AW-1:0] addend;
	logic signed [AW-1:0] sum;
	logic [AW-VW:0]       sum_hi;
	logic                 fits;

	// Partial product and final saturating sum
	always_comb begin
		addend = mpl_q[SW-1] ? AW'(mcand_q) : '0;
		sum    = acc_q + AW'(base_q);
		sum_hi = sum[AW-1:VW-1];
		fits   = (&sum_hi) || !(|sum_hi);
		if (fits) begin
			res = sum[VW-1:0];
		end else if (sum[AW-1]) begin
			res = ptsa_pkg::SAT_MIN;
		end else begin
			res = ptsa_pkg::SAT_MAX;
		end
	end

	assign done = busy_q && (cnt_q == '0);

	// Count down the multiplier bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(SW);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Shift-and-add one multiplier bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			mpl_q   <= ld.mplier;
			mcand_q <= ld.mcand;
			base_q  <= ld.base;
		end else if (busy_q && (cnt_q != '0)) begin
			acc_q <= (acc_q <<< 1) + addend;
			mpl_q <= {mpl_q[SW-2:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ptsa_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "perspective_texture_span_addresser_unit_defines.svh"

module ptsa_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_ready,
	input wire logic                        in_opcode,
	input wire logic                        out_valid,
	input wire logic                        out_ready,
	input wire logic [ptsa_pkg::IDX_W-1:0]  out_index,
	input wire logic                        out_last
);

	// A setup transfer always occupies the block for the next cycle
	`PTSA_ASSERT_NEXT(a_setup_busy, in_valid && in_ready && (in_opcode == ptsa_pkg::OP_SETUP), !in_ready, "setup transfer did not occupy the block")

	// A new result only appears after the block was occupied
	`PTSA_ASSERT_NOW(a_result_after_busy, $rose(out_valid), !$past(in_ready), "result appeared while the block was idle")

	// No result can follow an input transfer in the very next cycle
	`PTSA_ASSERT_NEXT(a_no_quick_result, in_valid && in_ready, !$rose(out_valid), "result appeared one cycle after an input transfer")

	// A stalled result holds its payload
	`PTSA_ASSERT_NEXT(a_hold_stalled, out_valid && !out_ready, out_valid && $stable(out_index) && $stable(out_last), "stalled result changed")

endmodule

bind perspective_texture_span_addresser_unit ptsa_chk u_ptsa_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_opcode (item.opcode),
	.out_valid (texel.valid),
	.out_ready (texel.ready),
	.out_index (texel.texel_index),
	.out_last  (texel.last_pixel)
);

`default_nettype wire
